[rtl/scr_pkg.sv]
// shared types and constants for the second-chance page replacer
package scr_pkg;

  localparam int unsigned CFG_W      = 4;
  localparam int unsigned FAULT_W    = 16;
  localparam int unsigned FIDX_OUT_W = 3;

  localparam logic [CFG_W-1:0]   CFG_FRAMES_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX        = 16'hFFFF;

  // register index of frames_in_use
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE,
    ST_SWEEP,
    ST_FINISH
  } scr_state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic resolve;
    logic sweep;
    logic load_out;
  } scr_cmd_t;

  typedef struct packed {
    logic hit;
    logic cur_use;
    logic out_free;
  } scr_sts_t;

endpackage

[rtl/second_chance_page_replacer.sv]
// top level of the second-chance (clock) page replacer
//
// input channel: one page_number_i per item, accepted when in_valid_i is high
// and in_stall_o is low. output channel: one result item per input item
// (was_hit_o, frame_index_o, faults_so_far_o), taken when out_valid_o is high
// and out_stall_i is low.
// a hit passes through lookup, resolve and finish; a miss also sweeps, and the
// clock hand clears each set use bit on its way, at most NUM_FRAMES of them.
// the hand sweep, one frame per cycle, sets the miss time.
// one item is in work at a time; the next is accepted in the cycle after the
// result enters the output register, even while that result is still stalled.
// a result that finds the output register full waits until it drains.
// reset empties all frames, clears use bits, hand and fault counter, and sets
// frames_in_use to 8. frames_in_use sits at byte address 0 of the apb port; the
// user must write it only while the block is idle; this is not enforced.
module second_chance_page_replacer #(
  parameter int unsigned NUM_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PAGE_BITS-1:0]            page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            was_hit_o,
  output logic [scr_pkg::FIDX_OUT_W-1:0]  frame_index_o,
  output logic [scr_pkg::FAULT_W-1:0]     faults_so_far_o
);
  import scr_pkg::*;

  logic [CFG_W-1:0] frames_in_use_q;
  logic             reg_sel;
  scr_cmd_t         cmd;
  scr_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_FRAMES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_FRAMES_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      frames_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - CFG_W){1'b0}}, frames_in_use_q} : '0;

  scr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .was_hit_o       (was_hit_o),
    .frame_index_o   (frame_index_o),
    .faults_so_far_o (faults_so_far_o)
  );

endmodule

[rtl/scr_ctrl.sv]
// controller state machine for the second-chance page replacer
module scr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  scr_pkg::scr_sts_t sts_i,
  output scr_pkg::scr_cmd_t cmd_o
);
  import scr_pkg::*;

  scr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = sts_i.hit ? ST_FINISH : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (!sts_i.cur_use) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/scr_dp.sv]
// datapath: frame table, use bits, clock hand, fault counter and output register
module scr_dp #(
  parameter int unsigned NUM_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [scr_pkg::CFG_W-1:0]       frames_in_use_i,
  input  logic [PAGE_BITS-1:0]            page_number_i,
  input  scr_pkg::scr_cmd_t               cmd_i,
  output scr_pkg::scr_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            was_hit_o,
  output logic [scr_pkg::FIDX_OUT_W-1:0]  frame_index_o,
  output logic [scr_pkg::FAULT_W-1:0]     faults_so_far_o
);
  import scr_pkg::*;

  localparam int unsigned FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_FRAMES + 1);

  logic [PAGE_BITS-1:0]  frame_page_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid_q;
  logic [NUM_FRAMES-1:0] use_q;
  logic [NUM_FRAMES-1:0] match_q;
  logic [NUM_FRAMES-1:0] match_d;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FIDX_W-1:0]     ptr_q;
  logic [FIDX_W-1:0]     ptr_adv;
  logic [FIDX_W-1:0]     slot_q;
  logic [FIDX_W-1:0]     first_hit;
  logic [FAULT_W-1:0]    fault_q;
  logic                  hit_q;
  logic [CNT_W-1:0]      n_active;
  logic [CNT_W-1:0]      ptr_ext;
  logic [CNT_W-1:0]      ptr_inc;
  logic [FIDX_W+FIDX_OUT_W-1:0] slot_ext;

  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [FIDX_OUT_W-1:0] out_idx_q;
  logic [FAULT_W-1:0]    out_faults_q;

  // active frame count, zero acts as one and large values clamp
  always_comb begin
    if (frames_in_use_i == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_in_use_i) > NUM_FRAMES) begin
      n_active = CNT_W'(NUM_FRAMES);
    end else begin
      n_active = CNT_W'(frames_in_use_i);
    end
  end

  // parallel compare lanes
  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cmp
    assign match_d[g] = frame_valid_q[g] && (frame_page_q[g] == page_q) &&
                        (CNT_W'(g) < n_active);
  end

  // lowest matching frame
  always_comb begin
    first_hit = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_hit = FIDX_W'(i);
      end
    end
  end

  assign ptr_ext = CNT_W'(ptr_q);
  assign ptr_inc = ptr_ext + CNT_W'(1);
  assign ptr_adv = (ptr_inc >= n_active) ? '0 : FIDX_W'(ptr_inc);

  assign sts_o.hit      = |match_q;
  assign sts_o.cur_use  = use_q[ptr_q];
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_number_i;
    end
    if (cmd_i.lookup) begin
      match_q <= match_d;
    end
    if (cmd_i.sweep && !use_q[ptr_q]) begin
      frame_page_q[ptr_q] <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      use_q         <= '0;
      ptr_q         <= '0;
      fault_q       <= '0;
      hit_q         <= 1'b0;
      slot_q        <= '0;
    end else begin
      if (cmd_i.resolve) begin
        hit_q <= |match_q;
        if (|match_q) begin
          use_q[first_hit] <= 1'b1;
          slot_q           <= first_hit;
        end else begin
          if (fault_q != FAULT_MAX) begin
            fault_q <= fault_q + FAULT_W'(1);
          end
          if (ptr_ext >= n_active) begin
            ptr_q <= '0;
          end
        end
      end
      if (cmd_i.sweep) begin
        ptr_q <= ptr_adv;
        if (use_q[ptr_q]) begin
          use_q[ptr_q] <= 1'b0;
        end else begin
          use_q[ptr_q]         <= 1'b1;
          frame_valid_q[ptr_q] <= 1'b1;
          slot_q               <= ptr_q;
        end
      end
    end
  end

  assign slot_ext = {{FIDX_OUT_W{1'b0}}, slot_q};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q    <= hit_q;
      out_idx_q    <= slot_ext[FIDX_OUT_W-1:0];
      out_faults_q <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign was_hit_o       = out_hit_q;
  assign frame_index_o   = out_idx_q;
  assign faults_so_far_o = out_faults_q;

endmodule
